/* rtl/ttr_pkg.sv */
// ----------------------------------------------------------------------------
// ttr_pkg: shared types and constants for the transposition table
// Field widths, request codes and the layout of the slot memories.
// ----------------------------------------------------------------------------
package ttr_pkg;

  // Field widths
  localparam int KEY_W   = 64;
  localparam int TAG_W   = 32;
  localparam int GEN_W   = 8;
  localparam int KIND_W  = 2;
  localparam int MOVE_W  = 16;
  localparam int SCORE_W = 32;
  localparam int DEPTH_W = 16;
  localparam int FUNC_W  = 2;
  localparam int CFG_W   = 5;

  // Table sizing
  localparam int                 INDEX_BITS_MAX_DEF = 16;
  localparam logic [CFG_W-1:0]   INDEX_BITS_RESET   = 5'd16;

  // Stream packing (padded to whole bytes)
  localparam int S_DATA_W = 136;
  localparam int M_DATA_W = 72;

  // Request codes
  localparam logic [FUNC_W-1:0] FUNC_PROBE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_STORE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NEW   = 2'd3;

  // Bound kind that marks an empty slot
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;

  // Tag memory entry: tag in the top bits, kind in the lowest
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [GEN_W-1:0]  gen;
    logic [KIND_W-1:0] kind;
  } meta_t;

  // Payload memory entry: move on top, depth in the lowest bits
  typedef struct packed {
    logic        [MOVE_W-1:0]  move;
    logic signed [SCORE_W-1:0] score;
    logic signed [DEPTH_W-1:0] depth;
  } payload_t;

  localparam int META_W = $bits(meta_t);
  localparam int PAY_W  = $bits(payload_t);

endpackage

/* rtl/ttr_ram.sv */
// ----------------------------------------------------------------------------
// ttr_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data registered, held when idle.
// ----------------------------------------------------------------------------
module ttr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, hold data between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/transposition_table_replace_top.sv */
// ----------------------------------------------------------------------------
// transposition_table_replace_top: direct-mapped search result table
// Probe, depth-preferred store, clear and new-search over two slot memories.
// ----------------------------------------------------------------------------
// A probe, store or new-search request reads the slot's tag and payload
// memories, then compares and writes back in the look state, which waits
// while the result register is full; no new transfer is taken until it ends.
// After reset and after a clear request the tag memory is swept one slot per
// cycle over all 2**INDEX_BITS_MAX slots (65536 at the default), during which
// no request is taken; the clear request's result is sent as the sweep starts.
// index_bits is to be written through cfg_we/cfg_wdata only while the block is
// idle, which the block itself does not enforce; clear the table after changing it.
module transposition_table_replace_top #(
  parameter int INDEX_BITS_MAX = ttr_pkg::INDEX_BITS_MAX_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // Configuration: index_bits
  input  logic                         cfg_we,
  input  logic [ttr_pkg::CFG_W-1:0]    cfg_wdata,
  // Request stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // key[63:0], best_move[79:64], score[111:80], search_depth[127:112],
  // bound_kind[129:128], zero pad[135:130]
  input  logic [ttr_pkg::S_DATA_W-1:0] s_axis_tdata,
  // func[1:0]
  input  logic [ttr_pkg::FUNC_W-1:0]   s_axis_tuser,
  // Result stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // hit_move[15:0], hit_score[47:16], hit_depth[63:48], hit_kind[65:64],
  // zero pad[71:66]
  output logic [ttr_pkg::M_DATA_W-1:0] m_axis_tdata,
  // hit[0]
  output logic                         m_axis_tuser
);

  localparam int SLOT_AW    = INDEX_BITS_MAX;
  localparam int SLOT_COUNT = 1 << INDEX_BITS_MAX;
  localparam logic [ttr_pkg::CFG_W-1:0] IDX_MAX = ttr_pkg::CFG_W'(INDEX_BITS_MAX);
  localparam logic [SLOT_AW-1:0] SLOT_LAST = {SLOT_AW{1'b1}};

  // Sequencer codes
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_LOOK  = 2'd2;

  logic [1:0]                  state;
  logic [1:0]                  state_next;
  logic [SLOT_AW-1:0]          clr_addr;
  logic [ttr_pkg::GEN_W-1:0]   generation;
  logic [ttr_pkg::CFG_W-1:0]   index_bits;

  // Request held across the read
  logic [ttr_pkg::FUNC_W-1:0]  item_func;
  logic [SLOT_AW-1:0]          item_slot;
  logic [ttr_pkg::TAG_W-1:0]   item_tag;
  ttr_pkg::payload_t           item_pay;
  logic [ttr_pkg::KIND_W-1:0]  item_kind;

  // Unpacked request fields
  logic [ttr_pkg::KEY_W-1:0]   in_key;
  ttr_pkg::payload_t           in_pay;
  logic [ttr_pkg::KIND_W-1:0]  in_kind;
  logic [ttr_pkg::CFG_W-1:0]   bits_eff;
  logic [SLOT_AW-1:0]          slot_mask;
  logic [SLOT_AW-1:0]          in_slot;

  // Memory ports
  logic                        meta_we;
  logic [SLOT_AW-1:0]          meta_waddr;
  ttr_pkg::meta_t              meta_wdata;
  ttr_pkg::meta_t              meta_rdata;
  logic                        pay_we;
  ttr_pkg::payload_t           pay_rdata;

  logic                        s_accept;
  logic                        out_load;
  logic                        hit;
  logic                        occupied;
  logic                        store_skip;
  logic                        store_write;

  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);
  assign out_load = (state == ST_LOOK) && (!m_axis_tvalid || m_axis_tready);

  // Unpack the request; the payload entry holds move on top, depth lowest
  assign in_key  = s_axis_tdata[63:0];
  assign in_pay  = {s_axis_tdata[79:64], s_axis_tdata[111:80], s_axis_tdata[127:112]};
  assign in_kind = s_axis_tdata[129:128];

  // Slot index: low key bits under the saturated index_bits mask
  always_comb begin
    bits_eff = (index_bits > IDX_MAX) ? IDX_MAX : index_bits;
    for (int i = 0; i < SLOT_AW; i++) begin
      slot_mask[i] = (ttr_pkg::CFG_W'(i) < bits_eff);
    end
    in_slot = in_key[SLOT_AW-1:0] & slot_mask;
  end

  // Compare the slot read against the held request
  assign hit = (meta_rdata.kind != ttr_pkg::KIND_NONE) && (meta_rdata.tag == item_tag);
  assign occupied = (meta_rdata.kind != ttr_pkg::KIND_NONE) && (meta_rdata.gen == generation);
  assign store_skip = occupied && (item_pay.depth < pay_rdata.depth);
  assign store_write = out_load && (item_func == ttr_pkg::FUNC_STORE) && !store_skip;

  // Tag memory write: clearing sweep or store write-back
  always_comb begin
    if (state == ST_CLEAR) begin
      meta_we    = 1'b1;
      meta_waddr = clr_addr;
      meta_wdata = '0;
    end else begin
      meta_we    = store_write;
      meta_waddr = item_slot;
      meta_wdata = '{tag: item_tag, gen: generation, kind: item_kind};
    end
  end

  assign pay_we = store_write;

  ttr_ram #(
    .WIDTH (ttr_pkg::META_W),
    .DEPTH (SLOT_COUNT)
  ) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .re    (s_accept),
    .raddr (in_slot),
    .rdata (meta_rdata)
  );

  ttr_ram #(
    .WIDTH (ttr_pkg::PAY_W),
    .DEPTH (SLOT_COUNT)
  ) u_pay_ram (
    .clk   (clk),
    .we    (pay_we),
    .waddr (item_slot),
    .wdata (item_pay),
    .re    (s_accept),
    .raddr (in_slot),
    .rdata (pay_rdata)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == SLOT_LAST) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_accept) state_next = ST_LOOK;
      end
      ST_LOOK: begin
        if (out_load) begin
          state_next = (item_func == ttr_pkg::FUNC_CLEAR) ? ST_CLEAR : ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      generation <= '0;
      index_bits <= ttr_pkg::INDEX_BITS_RESET;
    end else begin
      state <= state_next;
      if (cfg_we) index_bits <= cfg_wdata;
      // Advance the sweep, wrapping back to slot zero at the end
      if (state == ST_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (out_load) begin
        case (item_func)
          ttr_pkg::FUNC_CLEAR: generation <= '0;
          ttr_pkg::FUNC_NEW:   generation <= generation + 1'b1;
          default:             generation <= generation;
        endcase
      end
    end
  end

  // Hold the request while its slot is read
  always_ff @(posedge clk) begin
    if (s_accept) begin
      item_func <= s_axis_tuser;
      item_slot <= in_slot;
      item_tag  <= in_key[ttr_pkg::KEY_W-1:ttr_pkg::KEY_W-ttr_pkg::TAG_W];
      item_pay  <= in_pay;
      item_kind <= in_kind;
    end
  end

  // Result register: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // Result register: payload, zero unless a probe hit
  always_ff @(posedge clk) begin
    if (out_load) begin
      if ((item_func == ttr_pkg::FUNC_PROBE) && hit) begin
        m_axis_tuser <= 1'b1;
        m_axis_tdata <= {6'd0, meta_rdata.kind, pay_rdata.depth, pay_rdata.score,
                         pay_rdata.move};
      end else begin
        m_axis_tuser <= 1'b0;
        m_axis_tdata <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  // A clear request always starts a sweep
  a_clear_sweeps: assert property (@(posedge clk) disable iff (rst)
    (out_load && (item_func == ttr_pkg::FUNC_CLEAR)) |=> (state == ST_CLEAR))
    else $error("clear request did not start a sweep");

  // Generation stays zero through a sweep
  a_gen_zero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> (generation == '0))
    else $error("generation non-zero during clearing");

  // A write-back never coincides with a new read
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    s_accept |-> !meta_we)
    else $error("tag write overlaps slot read");

  // Results without a hit carry all-zero data
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("miss result carries data");
`endif

endmodule
